@@ rtl/core/nsm_pkg.sv @@
// Package: shared types and constants for the nerve stimulation monitor core.
`timescale 1ns / 1ps

package nsm_pkg;

    // Fixed field widths
    localparam int ALPHA_W   = 16;
    localparam int WEIGHT_W  = 24;
    localparam int FILT_W    = 32;
    localparam int TERM_W    = 32;
    localparam int THRESH_W  = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier: unsigned gain/coefficient times signed 33-bit operand
    localparam int MUL_A_W = WEIGHT_W + 1;
    localparam int MUL_B_W = FILT_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Rounding of the filter step, Q0.16 coefficient
    localparam int ALPHA_FRAC = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_TWO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THREE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THREE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STIM_THRESH  = 3'd6;

    // Register reset values
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'h8000;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 32'hFFFF_FFFF;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_F1   = 9'b0_0000_0010,
        S_F2   = 9'b0_0000_0100,
        S_F3   = 9'b0_0000_1000,
        S_T1   = 9'b0_0001_0000,
        S_T2   = 9'b0_0010_0000,
        S_T3   = 9'b0_0100_0000,
        S_SUM  = 9'b0_1000_0000,
        S_DONE = 9'b1_0000_0000
    } t_state;

    // Magnitude of a filter value, widened so the result is never negative
    function automatic logic signed [MUL_B_W-1:0] f_mag(input logic signed [FILT_W-1:0] v);
        logic signed [MUL_B_W-1:0] v_ext;
        v_ext = {v[FILT_W-1], v};
        return v[FILT_W-1] ? -v_ext : v_ext;
    endfunction

endpackage

@@ rtl/core/nerve_stimulation_monitor_core.sv @@
// Top level: per-axis nerve stimulation monitor with one shared multiplier.
// Sequence: each accepted sample runs through F1, F2, F3, T1, T2, T3, SUM and DONE;
//   the next is taken only back in IDLE. Six products (three filter steps, three
//   weighted terms) pass one after another through a single multiplier.
// Reset (synchronous, active low) restores the register defaults and clears the
//   previous sample, the three filters and the handshake state.
`timescale 1ns / 1ps

module nerve_stimulation_monitor_core
    import nsm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_first,
    // output channel
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [TERM_W-1:0]      o_term_one,
    output logic [TERM_W-1:0]      o_term_two,
    output logic [TERM_W-1:0]      o_term_three,
    output logic [TERM_W-1:0]      o_total,
    output logic                   o_over_limit,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int FRAC   = 31 - SAMPLE_BITS;
    localparam int SLEW_W = SAMPLE_BITS + 1;

    // Configuration registers
    logic [ALPHA_W-1:0]  r_alpha_one, r_alpha_two, r_alpha_three;
    logic [WEIGHT_W-1:0] r_weight_one, r_weight_two, r_weight_three;
    logic [THRESH_W-1:0] r_threshold;

    // Sequencer and state
    t_state                    r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic signed [FILT_W-1:0]  r_f1, r_f2, r_f3;
    logic signed [FILT_W-1:0]  r_x;
    logic [FILT_W-1:0]         r_ax;
    logic signed [PROD_W-1:0]  r_prod;
    logic [TERM_W-1:0]         r_t1, r_t2, r_t3;
    logic [TERM_W:0]           r_sum12;

    // Output register
    logic                      r_out_valid;
    logic [TERM_W-1:0]         r_o_t1, r_o_t2, r_o_t3, r_o_total;
    logic                      r_o_over;

    logic                      w_accept;
    logic                      w_out_load;
    logic signed [SLEW_W-1:0]  w_slew;
    logic signed [FILT_W-1:0]  w_x;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_filt_step;
    logic signed [FILT_W-1:0]  w_filt_inc;
    logic [PROD_W-1:0]         w_term_rnd;
    logic [PROD_W-1:0]         w_term_shift;
    logic [TERM_W-1:0]         w_term_sat;
    logic [TERM_W-1:0]         w_t3;
    logic [TERM_W+1:0]         w_sum;

    assign o_ready      = (r_state == S_IDLE);
    assign w_accept     = i_valid && o_ready;
    assign w_out_load   = (r_state == S_DONE) && (!r_out_valid || i_ready);

    assign o_valid      = r_out_valid;
    assign o_term_one   = r_o_t1;
    assign o_term_two   = r_o_t2;
    assign o_term_three = r_o_t3;
    assign o_total      = r_o_total;
    assign o_over_limit = r_o_over;

    // Slew in sample units, then scaled up by FRAC bits
    always_comb begin
        if (i_first) begin
            w_slew = {i_sample[SAMPLE_BITS-1], i_sample};
        end else begin
            w_slew = $signed({i_sample[SAMPLE_BITS-1], i_sample})
                   - $signed({r_prev[SAMPLE_BITS-1], r_prev});
        end
        w_x = $signed({w_slew, {FRAC{1'b0}}});
    end

    // Operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_F1: begin
                w_mul_a = $signed({{(MUL_A_W-ALPHA_W){1'b0}}, r_alpha_one});
                w_mul_b = $signed({r_x[FILT_W-1], r_x}) - $signed({r_f1[FILT_W-1], r_f1});
            end
            S_F2: begin
                w_mul_a = $signed({{(MUL_A_W-ALPHA_W){1'b0}}, r_alpha_two});
                w_mul_b = $signed({1'b0, r_ax}) - $signed({r_f2[FILT_W-1], r_f2});
            end
            S_F3: begin
                w_mul_a = $signed({{(MUL_A_W-ALPHA_W){1'b0}}, r_alpha_three});
                w_mul_b = $signed({r_x[FILT_W-1], r_x}) - $signed({r_f3[FILT_W-1], r_f3});
            end
            S_T1: begin
                w_mul_a = $signed({1'b0, r_weight_one});
                w_mul_b = f_mag(r_f1);
            end
            S_T2: begin
                w_mul_a = $signed({1'b0, r_weight_two});
                w_mul_b = f_mag(r_f2);
            end
            S_T3: begin
                w_mul_a = $signed({1'b0, r_weight_three});
                w_mul_b = f_mag(r_f3);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Filter step: round half up, drop the Q0.16 fraction
    assign w_filt_step = (r_prod + $signed(PROD_W'(1 << (ALPHA_FRAC - 1)))) >>> ALPHA_FRAC;
    assign w_filt_inc  = w_filt_step[FILT_W-1:0];

    // Weighted term: round half up, drop FRAC bits, saturate to 32 bits
    assign w_term_rnd   = $unsigned(r_prod) + (PROD_W'(1) << (FRAC - 1));
    assign w_term_shift = w_term_rnd >> FRAC;
    assign w_term_sat   = (|w_term_shift[PROD_W-1:TERM_W]) ? '1 : w_term_shift[TERM_W-1:0];

    // Third term and total; zero third weight is the two-term mode
    assign w_t3  = (r_weight_three == '0) ? '0 : r_t3;
    assign w_sum = {1'b0, r_sum12} + {2'b00, w_t3};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_F1;
            S_F1:   n_state = S_F2;
            S_F2:   n_state = S_F3;
            S_F3:   n_state = S_T1;
            S_T1:   n_state = S_T2;
            S_T2:   n_state = S_T3;
            S_T3:   n_state = S_SUM;
            S_SUM:  n_state = S_DONE;
            S_DONE: if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_one    <= ALPHA_RESET;
            r_alpha_two    <= ALPHA_RESET;
            r_alpha_three  <= ALPHA_RESET;
            r_weight_one   <= '0;
            r_weight_two   <= '0;
            r_weight_three <= '0;
            r_threshold    <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALPHA_ONE:    r_alpha_one    <= i_cfg_data[ALPHA_W-1:0];
                CFG_ALPHA_TWO:    r_alpha_two    <= i_cfg_data[ALPHA_W-1:0];
                CFG_ALPHA_THREE:  r_alpha_three  <= i_cfg_data[ALPHA_W-1:0];
                CFG_WEIGHT_ONE:   r_weight_one   <= i_cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_TWO:   r_weight_two   <= i_cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_THREE: r_weight_three <= i_cfg_data[WEIGHT_W-1:0];
                CFG_STIM_THRESH:  r_threshold    <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, previous sample and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_f1        <= '0;
            r_f2        <= '0;
            r_f3        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_prev <= i_sample;
                if (i_first) begin
                    r_f1 <= '0;
                    r_f2 <= '0;
                    r_f3 <= '0;
                end
            end
            if (r_state == S_F2) r_f1 <= r_f1 + w_filt_inc;
            if (r_state == S_F3) r_f2 <= r_f2 + w_filt_inc;
            if (r_state == S_T1) r_f3 <= r_f3 + w_filt_inc;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x  <= w_x;
            r_ax <= w_x[FILT_W-1] ? FILT_W'(-w_x) : FILT_W'(w_x);
        end
        r_prod <= w_prod;
        if (r_state == S_T2) r_t1 <= w_term_sat;
        if (r_state == S_T3) begin
            r_t2    <= w_term_sat;
            r_sum12 <= {1'b0, r_t1} + {1'b0, w_term_sat};
        end
        if (r_state == S_SUM) r_t3 <= w_term_sat;
        if (w_out_load) begin
            r_o_t1    <= r_t1;
            r_o_t2    <= r_t2;
            r_o_t3    <= w_t3;
            r_o_total <= (|w_sum[TERM_W+1:TERM_W]) ? '1 : w_sum[TERM_W-1:0];
            r_o_over  <= ((|w_sum[TERM_W+1:TERM_W]) ? '1 : w_sum[TERM_W-1:0]) > r_threshold;
        end
    end

`ifndef SYNTHESIS
    // An accepted sample keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("input ready while a sample is in work");

    // A presented total is never below the first term
    a_total_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_total >= o_term_one))
        else $error("total below term one");

    // Output register only loads from the final sequencer step
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && $past(i_rst_n) && $past(o_valid) == 1'b0 && o_valid == 1'b0)
            |=> (o_valid == 1'b0 || $past(r_state) == S_DONE))
        else $error("output became valid outside the final step");
`endif

endmodule

@@ dv/nerve_stimulation_monitor_core_tb.sv @@
// Testbench: nerve stimulation monitor core, self-checking against a cycle-free predictor.
`timescale 1ns / 1ps

module nerve_stimulation_monitor_core_tb;
    import nsm_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC        = 31 - SAMPLE_BITS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_GAP   = 16;
    localparam int LONG_HOLD   = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic [TERM_W-1:0] term_one;
        logic [TERM_W-1:0] term_two;
        logic [TERM_W-1:0] term_three;
        logic [TERM_W-1:0] total;
        logic              over_limit;
    } t_stim_result;

    // Predicts the stimulation terms per sample and checks them in order
    class stim_scoreboard;
        logic [ALPHA_W-1:0]  alpha [3];
        logic [WEIGHT_W-1:0] weight [3];
        logic [THRESH_W-1:0] threshold;
        longint              prev_sample;
        longint              filt_val [3];
        t_stim_result        expected_stim [$];
        int                  errors;

        function new();
            foreach (alpha[k]) begin
                alpha[k]    = ALPHA_RESET;
                weight[k]   = '0;
                filt_val[k] = 0;
            end
            threshold   = THRESH_RESET;
            prev_sample = 0;
            errors      = 0;
        endfunction

        // Bits above a register's width drop; unknown indexes do nothing
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ALPHA_ONE:    alpha[0]  = data[ALPHA_W-1:0];
                CFG_ALPHA_TWO:    alpha[1]  = data[ALPHA_W-1:0];
                CFG_ALPHA_THREE:  alpha[2]  = data[ALPHA_W-1:0];
                CFG_WEIGHT_ONE:   weight[0] = data[WEIGHT_W-1:0];
                CFG_WEIGHT_TWO:   weight[1] = data[WEIGHT_W-1:0];
                CFG_WEIGHT_THREE: weight[2] = data[WEIGHT_W-1:0];
                CFG_STIM_THRESH:  threshold = data[THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        // y += round(alpha * (x - y) / 2^16), ties toward plus infinity
        function longint lowpass(longint y, longint x, logic [ALPHA_W-1:0] a);
            longint d;
            d = longint'({48'd0, a}) * (x - y) + 64'sd32768;
            return y + (d >>> 16);
        endfunction

        // round(weight * |v| / 2^FRAC), saturated to 32 bits
        function logic [TERM_W-1:0] weigh(logic [WEIGHT_W-1:0] w, longint v);
            logic [63:0] mag;
            logic [63:0] p;
            mag = (v < 0) ? -v : v;
            p   = {40'd0, w} * mag;
            p   = (p + (64'd1 << (FRAC - 1))) >> FRAC;
            return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[TERM_W-1:0];
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] raw, logic first);
            longint       s;
            longint       x;
            longint       ax;
            logic [33:0]  sum;
            t_stim_result r;
            s = $signed(raw);
            if (first) begin
                prev_sample = 0;
                foreach (filt_val[k]) filt_val[k] = 0;
            end
            x           = (s - prev_sample) <<< FRAC;
            ax          = (x < 0) ? -x : x;
            prev_sample = s;
            filt_val[0] = lowpass(filt_val[0], x, alpha[0]);
            filt_val[1] = lowpass(filt_val[1], ax, alpha[1]);
            filt_val[2] = lowpass(filt_val[2], x, alpha[2]);
            r.term_one   = weigh(weight[0], filt_val[0]);
            r.term_two   = weigh(weight[1], filt_val[1]);
            // two-term mode: filter three still runs, its term is forced to zero
            r.term_three = (weight[2] == '0) ? '0 : weigh(weight[2], filt_val[2]);
            sum = {2'b00, r.term_one} + {2'b00, r.term_two} + {2'b00, r.term_three};
            r.total      = (sum > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[TERM_W-1:0];
            r.over_limit = (r.total > threshold);
            expected_stim = {expected_stim, r};
        endfunction

        function void compare_field(string name, logic [TERM_W-1:0] want,
                                    logic [TERM_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_stim_result got);
            t_stim_result want;
            if (expected_stim.size() == 0) begin
                $error("result transaction with no sample pending");
                errors++;
                return;
            end
            want = expected_stim.pop_front();
            compare_field("term_one", want.term_one, got.term_one);
            compare_field("term_two", want.term_two, got.term_two);
            compare_field("term_three", want.term_three, got.term_three);
            compare_field("total", want.total, got.total);
            compare_field("over_limit", {31'd0, want.over_limit}, {31'd0, got.over_limit});
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_ready;
    logic [SAMPLE_BITS-1:0] i_sample    = '0;
    logic                   i_first     = 1'b0;
    logic                   o_valid;
    logic                   i_ready     = 1'b0;
    logic [TERM_W-1:0]      o_term_one;
    logic [TERM_W-1:0]      o_term_two;
    logic [TERM_W-1:0]      o_term_three;
    logic [TERM_W-1:0]      o_total;
    logic                   o_over_limit;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data  = '0;

    stim_scoreboard sb;
    int samples_sent  = 0;
    int results_taken = 0;
    int cycle_count   = 0;

    nerve_stimulation_monitor_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .i_first     (i_first),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_term_one  (o_term_one),
        .o_term_two  (o_term_two),
        .o_term_three(o_term_three),
        .o_total     (o_total),
        .o_over_limit(o_over_limit),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitor both channels at the edge where transactions complete
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check_result({o_term_one, o_term_two, o_term_three, o_total, o_over_limit});
            end
            if (i_valid && o_ready) begin
                sb.note_sample(i_sample, i_first);
            end
        end
    end

    // Sender idle draw, with stretches of back-to-back transactions
    function automatic int pick_gap(int count);
        if (((count >> 6) & 3) == 3) return 0;
        return $urandom_range(0, 11);
    endfunction

    // Fill bits above the register width with junk
    function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] v, int w);
        if (w >= CFG_W) return v;
        return ($urandom() << w) | v;
    endfunction

    task automatic offer_sample(input int s, input logic f);
        int gap;
        gap = pick_gap(samples_sent);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= SAMPLE_BITS'(s);
        i_first  <= f;
        do @(posedge i_clk); while (!o_ready);
        samples_sent++;
    endtask

    // Receiver: random stalls, stall-free stretches and two long hold-offs
    task automatic drain_results();
        int stall;
        forever begin
            if (results_taken == 150 || results_taken == 1000) begin
                stall = LONG_HOLD;
            end else if (((results_taken >> 5) % 3) == 2) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 11);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            results_taken++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs(input int a1, input int a2, input int a3,
                                input int w1, input int w2, input int w3,
                                input logic [THRESH_W-1:0] thr);
        write_reg(CFG_ALPHA_ONE, with_junk(CFG_W'(a1), ALPHA_W));
        write_reg(CFG_ALPHA_TWO, with_junk(CFG_W'(a2), ALPHA_W));
        write_reg(CFG_ALPHA_THREE, with_junk(CFG_W'(a3), ALPHA_W));
        write_reg(CFG_WEIGHT_ONE, with_junk(CFG_W'(w1), WEIGHT_W));
        write_reg(CFG_WEIGHT_TWO, with_junk(CFG_W'(w2), WEIGHT_W));
        write_reg(CFG_WEIGHT_THREE, with_junk(CFG_W'(w3), WEIGHT_W));
        write_reg(CFG_STIM_THRESH, thr);
        // must be ignored
        write_reg(CFG_UNUSED_IDX, $urandom());
    endtask

    // Close a burst and wait until the block has gone idle
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.expected_stim.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    function automatic int pick_alpha();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65535;
            2: return 32768;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int pick_weight();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 24'hFF_FFFF;
            2: return $urandom_range(0, 65536);
            3: return $urandom_range(0, 255);
            default: return int'($urandom() & 32'h00FF_FFFF);
        endcase
    endfunction

    function automatic logic [THRESH_W-1:0] pick_threshold();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 1 << 20);
            default: return $urandom();
        endcase
    endfunction

    // Gradient waveform: zero start marked first, then one to three trapezoid lobes
    task automatic send_waveform();
        int lobes;
        int amp;
        int ramp;
        int flat;
        offer_sample(0, 1'b1);
        lobes = $urandom_range(1, 3);
        repeat (lobes) begin
            amp  = int'($urandom_range(0, 65535)) - 32768;
            ramp = $urandom_range(1, 8);
            flat = $urandom_range(0, 10);
            for (int k = 1; k <= ramp; k++) offer_sample(amp * k / ramp, 1'b0);
            repeat (flat) offer_sample(amp, 1'b0);
            for (int k = ramp - 1; k >= 0; k--) offer_sample(amp * k / ramp, 1'b0);
        end
    endtask

    initial begin
        int phase_end;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            drain_results();
        join_none

        // Register defaults: zero weights give zero terms, threshold never crossed
        offer_sample(16'h1234, 1'b0);
        offer_sample(-5, 1'b0);
        wait_drained();

        // Full-scale coefficients and gains, zero threshold: slew extremes, saturation
        program_regs(65535, 65535, 65535, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, '0);
        offer_sample(32767, 1'b1);
        offer_sample(-32768, 1'b0);
        offer_sample(32767, 1'b0);
        offer_sample(32767, 1'b0);
        offer_sample(-32768, 1'b1);
        offer_sample(0, 1'b0);
        offer_sample(1, 1'b0);
        offer_sample(-1, 1'b0);
        wait_drained();

        // Frozen filters, two-term mode, maximum threshold
        program_regs(0, 0, 0, 1, 1, 0, '1);
        offer_sample(1000, 1'b1);
        offer_sample(-1000, 1'b0);
        offer_sample(0, 1'b0);
        wait_drained();

        // Unit gains and tiny slews: exercises rounding ties in both stages
        program_regs(1, 32768, 65535, 24'h01_0000, 24'h00_8000, 1, 32'h0001_0000);
        offer_sample(1, 1'b1);
        offer_sample(0, 1'b0);
        offer_sample(1, 1'b0);
        offer_sample(3, 1'b0);
        offer_sample(-2, 1'b0);
        offer_sample(32767, 1'b0);
        offer_sample(-32768, 1'b0);
        wait_drained();

        // Random phases: mostly well-formed waveforms, some raw noise
        for (int p = 0; p < 12; p++) begin
            program_regs(pick_alpha(), pick_alpha(), pick_alpha(),
                         pick_weight(), pick_weight(),
                         ($urandom_range(0, 3) == 0) ? 0 : pick_weight(),
                         pick_threshold());
            phase_end = samples_sent + 125;
            while (samples_sent < phase_end) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_waveform();
                end else begin
                    repeat ($urandom_range(1, 12)) begin
                        offer_sample(int'($urandom_range(0, 65535)),
                                     $urandom_range(0, 7) == 0);
                    end
                end
            end
            wait_drained();
        end

        if (sb.expected_stim.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_stim.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
